FILE: design/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int SAMPLE_W       = 10;
  localparam int GEAR_W         = 8;
  localparam int MID_W          = 10;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_INDEX_W    = 1;
  localparam int ANGLE_BITS     = 16;
  localparam int DEF_WINDOW     = 10;
  localparam int DEF_TOTAL_BITS = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_GEAR_REDUCTION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADC_MIDPOINT   = 1'd1;

  localparam logic [GEAR_W-1:0] GEAR_RESET = 8'd36;
  localparam logic [MID_W-1:0]  MID_RESET  = 10'd512;

  localparam int CORDIC_STEPS   = 24;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int PRESCALE_SHIFT = 12;
  localparam int TURN_W         = 32;

  typedef struct packed {
    logic                  done;
    logic [ANGLE_BITS-1:0] angle;
  } sct_angle_res_t;

  // atan(2^-i) as a 32-bit fraction of a turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [TURN_W-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/sincos_encoder_angle_tracker_top.sv
// sine/cosine encoder angle tracker
//
// input channel (in_valid/in_ready) takes one sine and one cosine converter
// sample per transaction. output channel (out_valid/out_ready) gives one
// result per input: shaft angle, single-turn motor angle and a flag that is
// set when the multi-turn total sits at its limit.
// configuration: cfg_write with cfg_index 0 sets gear_reduction, 1 sets
// adc_midpoint; write only while no transaction is in flight.
// one item at a time: in_ready is high only while the sequencer is idle.
// an item passes from acceptance to out_valid through the window update,
// the iterative cordic unit (24 micro-rotations), the accumulation of the
// total, the bit-serial divider, the output state and the load of the output
// register; the cordic rotations are skipped when either centred sum is zero.
// a new item is taken only once the previous one has left the output state.
// the output register frees the input side: a new item is accepted while
// a result waits; its own result is held back until the receiver takes the
// previous one.
// reset clears the sample windows, sums, previous angle and total, and
// loads gear_reduction = 36 and adc_midpoint = 512.
`timescale 1ns / 1ps
`default_nettype none

module sincos_encoder_angle_tracker_top
  import sct_pkg::*;
#(
  parameter int WINDOW     = DEF_WINDOW,
  parameter int TOTAL_BITS = DEF_TOTAL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_W-1:0]    sin_sample,
  input  wire logic [SAMPLE_W-1:0]    cos_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ANGLE_BITS-1:0]       shaft_angle,
  output logic [ANGLE_BITS-1:0]       motor_angle,
  output logic                        total_saturated
);

  localparam int SUM_W = $clog2(WINDOW*((1<<SAMPLE_W)-1)+1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WIN    = 3'd1;
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  logic [2:0]                    state;
  logic [GEAR_W-1:0]             gear_reduction;
  logic [MID_W-1:0]              adc_midpoint;
  logic [ANGLE_BITS-1:0]         prev_angle;
  logic signed [TOTAL_BITS-1:0]  total;
  logic                          sat_flag;
  logic [ANGLE_BITS-1:0]         motor_hold;
  logic                          cordic_start;
  logic                          div_start;

  logic                          accept;
  logic                          win_done;
  logic [SUM_W-1:0]              sin_sum;
  logic [SUM_W-1:0]              cos_sum;
  logic [SUM_W-1:0]              offset;
  logic signed [SUM_W:0]         x_off;
  logic signed [SUM_W:0]         y_off;
  sct_angle_res_t                cord_res;
  logic                          div_done;
  logic [ANGLE_BITS-1:0]         quotient;
  logic [GEAR_W-1:0]             divisor;

  logic signed [ANGLE_BITS-1:0]  delta;
  logic signed [TOTAL_BITS:0]    total_sum;
  logic signed [TOTAL_BITS-1:0]  total_next;
  logic                          out_load;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign offset = SUM_W'(WINDOW) * SUM_W'(adc_midpoint);
  assign y_off  = $signed({1'b0, sin_sum}) - $signed({1'b0, offset});
  assign x_off  = $signed({1'b0, cos_sum}) - $signed({1'b0, offset});

  assign divisor = (gear_reduction == '0) ? GEAR_W'(1) : gear_reduction;

  // wrapped change, half a turn reads as minus half
  assign delta     = $signed(cord_res.angle - prev_angle);
  assign total_sum = $signed({total[TOTAL_BITS-1], total}) + (TOTAL_BITS+1)'(delta);

  always_comb begin
    if (total_sum[TOTAL_BITS] != total_sum[TOTAL_BITS-1]) begin
      total_next = total_sum[TOTAL_BITS] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_next = total_sum[TOTAL_BITS-1:0];
    end
  end

  sct_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .sin_in  (sin_sample),
    .cos_in  (cos_sample),
    .done    (win_done),
    .sin_sum (sin_sum),
    .cos_sum (cos_sum)
  );

  sct_cordic #(
    .SUM_W (SUM_W)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (x_off),
    .y_in  (y_off),
    .res   (cord_res)
  );

  sct_divider #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_reduction <= GEAR_RESET;
      adc_midpoint   <= MID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GEAR_REDUCTION: gear_reduction <= cfg_data[GEAR_W-1:0];
        REG_ADC_MIDPOINT:   adc_midpoint   <= cfg_data[MID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_angle   <= '0;
      total        <= '0;
      cordic_start <= 1'b0;
      div_start    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      cordic_start <= 1'b0;
      div_start    <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_done) begin
            cordic_start <= 1'b1;
            state        <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cord_res.done) begin
            total      <= total_next;
            prev_angle <= cord_res.angle;
            div_start  <= 1'b1;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_CORDIC) && cord_res.done) begin
      motor_hold <= cord_res.angle;
      sat_flag   <= (total_next == TOTAL_MAX) || (total_next == TOTAL_MIN);
    end
    if (out_load) begin
      shaft_angle     <= quotient;
      motor_angle     <= motor_hold;
      total_saturated <= sat_flag;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_cordic_in_state: assert property (@(posedge clk) disable iff (rst)
    cord_res.done |-> (state == S_CORDIC))
    else $error("cordic result outside its sequencer state");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result outside its sequencer state");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("result register not loaded on leaving output state");

endmodule

`default_nettype wire

FILE: design/sct_window.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_window
  import sct_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] sin_in,
  input  wire logic [SAMPLE_W-1:0] cos_in,
  output logic                     done,
  output logic [$clog2(WINDOW*((1<<SAMPLE_W)-1)+1)-1:0] sin_sum,
  output logic [$clog2(WINDOW*((1<<SAMPLE_W)-1)+1)-1:0] cos_sum
);

  localparam int SUM_W = $clog2(WINDOW*((1<<SAMPLE_W)-1)+1);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMPLE_W-1:0] sin_mem [WINDOW];
  logic [SAMPLE_W-1:0] cos_mem [WINDOW];
  logic [WINDOW-1:0]   filled;
  logic [POS_W-1:0]    pos;
  logic                update;
  logic [SAMPLE_W-1:0] sin_new;
  logic [SAMPLE_W-1:0] cos_new;
  logic [SAMPLE_W-1:0] sin_old;
  logic [SAMPLE_W-1:0] cos_old;

  always_ff @(posedge clk) begin
    if (update) begin
      sin_mem[pos] <= sin_new;
      cos_mem[pos] <= cos_new;
    end
  end

  // registered read of the slot that is about to be overwritten
  always_ff @(posedge clk) begin
    if (start) begin
      sin_new <= sin_in;
      cos_new <= cos_in;
      sin_old <= filled[pos] ? sin_mem[pos] : '0;
      cos_old <= filled[pos] ? cos_mem[pos] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled  <= '0;
      pos     <= '0;
      update  <= 1'b0;
      done    <= 1'b0;
      sin_sum <= '0;
      cos_sum <= '0;
    end else begin
      update <= start;
      done   <= update;
      if (update) begin
        sin_sum     <= sin_sum - SUM_W'(sin_old) + SUM_W'(sin_new);
        cos_sum     <= cos_sum - SUM_W'(cos_old) + SUM_W'(cos_new);
        filled[pos] <= 1'b1;
        if (pos == POS_W'(WINDOW - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/sct_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_cordic
  import sct_pkg::*;
#(
  parameter int SUM_W = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W:0]   x_in,
  input  wire logic signed [SUM_W:0]   y_in,
  output sct_angle_res_t               res
);

  localparam int CW = SUM_W + 15;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [TURN_W-1:0]     ROUND_HALF   = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);

  logic                    busy;
  logic                    fin;
  logic                    done;
  logic [STEP_W-1:0]       step;
  logic signed [CW-1:0]    x;
  logic signed [CW-1:0]    y;
  logic [TURN_W-1:0]       z;
  logic [ANGLE_BITS-1:0]   angle;

  logic signed [CW-1:0]    x_ext;
  logic signed [CW-1:0]    y_ext;
  logic signed [CW-1:0]    dx;
  logic signed [CW-1:0]    dy;
  logic [TURN_W-1:0]       z_round;
  logic                    special;
  logic [ANGLE_BITS-1:0]   special_angle;

  assign x_ext   = CW'(x_in) <<< PRESCALE_SHIFT;
  assign y_ext   = CW'(y_in) <<< PRESCALE_SHIFT;
  assign dx      = y >>> step;
  assign dy      = x >>> step;
  assign z_round = z + ROUND_HALF;
  assign special = (x_in == '0) || (y_in == '0);

  always_comb begin
    if (y_in == '0) begin
      special_angle = (x_in < 0) ? HALF_TURN : '0;
    end else if (y_in > 0) begin
      special_angle = QUARTER_TURN;
    end else begin
      special_angle = HALF_TURN + QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        done <= special;
        busy <= !special;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left half plane folds onto the right one, starting at half a turn
      if (x_in < 0) begin
        x <= -x_ext;
        y <= -y_ext;
        z <= TURN_W'(1) << (TURN_W - 1);
      end else begin
        x <= x_ext;
        y <= y_ext;
        z <= '0;
      end
      angle <= special_angle;
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_turn(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_turn(step);
      end
    end else if (fin) begin
      angle <= z_round[TURN_W-1 -: ANGLE_BITS];
    end
  end

  assign res = {done, angle};

endmodule

`default_nettype wire

FILE: design/sct_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_divider
  import sct_pkg::*;
#(
  parameter int TOTAL_BITS = DEF_TOTAL_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [TOTAL_BITS-1:0] dividend,
  input  wire logic [GEAR_W-1:0]            divisor,
  output logic                              done,
  output logic [ANGLE_BITS-1:0]             quotient
);

  localparam int CNT_W = $clog2(TOTAL_BITS);

  logic                  busy;
  logic                  fin;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic [TOTAL_BITS-1:0] mag;
  logic [GEAR_W-1:0]     rem;

  logic [GEAR_W:0]       rem_sh;
  logic [GEAR_W:0]       rem_sub;
  logic                  ge;
  logic [ANGLE_BITS-1:0] q_low;

  assign rem_sh  = {rem, mag[TOTAL_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign q_low   = mag[ANGLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(TOTAL_BITS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // restoring division of the magnitude, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend < 0;
      mag <= (dividend < 0) ? TOTAL_BITS'(-dividend) : TOTAL_BITS'(dividend);
      rem <= '0;
    end else if (busy) begin
      mag <= {mag[TOTAL_BITS-2:0], ge};
      rem <= ge ? rem_sub[GEAR_W-1:0] : rem_sh[GEAR_W-1:0];
    end
    if (fin) begin
      // floor for negative totals: -q when exact, -q-1 otherwise
      quotient <= neg ? (~q_low + ANGLE_BITS'(rem == '0)) : q_low;
    end
  end

endmodule

`default_nettype wire
